// ===== hw/rtl/tge_pkg.sv =====
// Shared types, constants and helper functions for the tensor gather block.
// No dependencies; imported by tge_addr and the top level.
package tge_pkg;

  localparam int unsigned STORE_WORDS = 4096;
  localparam int unsigned DIM_MAX     = 1024;

  localparam int unsigned ADDR_W = $clog2(STORE_WORDS);
  localparam int unsigned DIM_W  = $clog2(DIM_MAX) + 1;  // raw size field width
  localparam int unsigned IDX_W  = $clog2(DIM_MAX);      // clamped index width
  localparam int unsigned POS_W  = 10;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned GIDX_W = 32;
  localparam int unsigned STEP_W = 13;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RANK     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP     = 3'd5;

  // item commands
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_GATHER = 1'b1;

  typedef struct packed {
    logic [1:0]        rank;
    logic signed [2:0] gather_axis;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [DIM_W-1:0]  channels;
    logic [STEP_W-1:0] channel_step;
  } tge_cfg_t;

  // zero counts as one, oversize saturates at DIM_MAX
  function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] raw);
    logic [DIM_W-1:0] res;
    if (raw == '0) begin
      res = DIM_W'(1);
    end else if (raw > DIM_W'(DIM_MAX)) begin
      res = DIM_W'(DIM_MAX);
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/tge_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tge_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/tge_addr.sv =====
// Gather address unit: axis check, index wrap/clamp, then multiply and sum.
// Depends on tge_pkg. Three register stages from start_i to done_o.
module tge_addr
  import tge_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tge_cfg_t                 cfg_i,
  input  logic                     start_i,
  input  logic signed [GIDX_W-1:0] index_i,
  input  logic [POS_W-1:0]         pos_z_i,
  input  logic [POS_W-1:0]         pos_y_i,
  input  logic [POS_W-1:0]         pos_x_i,
  output logic                     err_o,
  output logic                     done_o,
  output logic [ADDR_W-1:0]        addr_o
);

  // axis normalization, config only
  logic signed [3:0]  ax_s;
  logic [1:0]         ax;
  logic [DIM_W-1:0]   w_c, h_c, c_c, size;

  always_comb begin
    ax_s = {cfg_i.gather_axis[2], cfg_i.gather_axis};
    if (ax_s < 0) begin
      ax_s = ax_s + signed'({2'b00, cfg_i.rank});
    end
    err_o = (cfg_i.rank == 2'd0) || (ax_s < 0) || (ax_s >= signed'({2'b00, cfg_i.rank}));
    ax    = ax_s[1:0];
    w_c   = dim_clamp(cfg_i.width);
    h_c   = dim_clamp(cfg_i.height);
    c_c   = dim_clamp(cfg_i.channels);
    case (cfg_i.rank)
      2'd2:    size = (ax == 2'd0) ? h_c : w_c;
      2'd3:    size = (ax == 2'd0) ? c_c : ((ax == 2'd1) ? h_c : w_c);
      default: size = w_c;
    endcase
  end

  // stage 1: wrap and clamp
  logic signed [GIDX_W:0] idx_adj;
  logic signed [GIDX_W:0] size_s;
  logic [IDX_W-1:0]       g_d, g_q;
  logic [POS_W-1:0]       z_q, y_q, x_q;

  always_comb begin
    size_s  = signed'({{(GIDX_W + 1 - DIM_W){1'b0}}, size});
    idx_adj = {index_i[GIDX_W-1], index_i};
    if (idx_adj < 0) begin
      idx_adj = idx_adj + size_s;
    end
    if (idx_adj < 0) begin
      g_d = '0;
    end else if (idx_adj >= size_s) begin
      g_d = IDX_W'(size - DIM_W'(1));
    end else begin
      g_d = idx_adj[IDX_W-1:0];
    end
  end

  // stage 2: products, mod 2^ADDR_W
  logic [ADDR_W-1:0] g_a, z_a, y_a, x_a, w_a, cs_a;
  logic [ADDR_W-1:0] mul_a_op, mul_b_op, term_c;
  logic [ADDR_W-1:0] prod_a_q, prod_b_q, term_c_q;
  logic [2*ADDR_W-1:0] prod_a, prod_b;

  always_comb begin
    g_a  = ADDR_W'(g_q);
    z_a  = ADDR_W'(z_q);
    y_a  = ADDR_W'(y_q);
    x_a  = ADDR_W'(x_q);
    w_a  = ADDR_W'(w_c);
    cs_a = ADDR_W'(cfg_i.channel_step);
    case (cfg_i.rank)
      2'd2: begin
        mul_a_op = '0;
        mul_b_op = (ax == 2'd0) ? g_a : y_a;
        term_c   = (ax == 2'd0) ? x_a : g_a;
      end
      2'd3: begin
        mul_a_op = (ax == 2'd0) ? g_a : z_a;
        mul_b_op = (ax == 2'd1) ? g_a : y_a;
        term_c   = (ax == 2'd2) ? g_a : x_a;
      end
      default: begin
        mul_a_op = '0;
        mul_b_op = '0;
        term_c   = g_a;
      end
    endcase
    prod_a = mul_a_op * cs_a;
    prod_b = mul_b_op * w_a;
  end

  // stage 3: sum
  logic [ADDR_W-1:0] addr_q;
  logic [2:0]        v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      g_q <= g_d;
      z_q <= pos_z_i;
      y_q <= pos_y_i;
      x_q <= pos_x_i;
    end
    if (v_q[0]) begin
      prod_a_q <= prod_a[ADDR_W-1:0];
      prod_b_q <= prod_b[ADDR_W-1:0];
      term_c_q <= term_c;
    end
    if (v_q[1]) begin
      addr_q <= prod_a_q + prod_b_q + term_c_q;
    end
  end

  assign done_o = v_q[2];
  assign addr_o = addr_q;

endmodule

// ===== hw/rtl/tensor_gather_elements_top.sv =====
// Top level of the tensor gather block: config registers, control, store, output.
// Depends on tge_pkg, tge_ram and tge_addr.
//
// Element gather over a tensor of rank 1..3 held in a 4096 x 32-bit store.
// A load transaction (cmd 0) writes load_value at load_addr on acceptance;
// it gives no result. A gather transaction (cmd 1) wraps a negative
// gather_index by the size of the chosen axis, clamps it to 0..size-1, builds
// the store address from the position, width and channel_step (mod 4096), and
// returns the stored word with that address. A bad rank/axis combination
// returns error=1 with value and source_addr zero. A gather passes through
// acceptance with wrap/clamp, the multiply stage, the sum stage, the store
// read and the output load; an error gather goes from acceptance straight to
// the output load. No new transaction is accepted until the result has moved
// to the output register, where it waits while the next one is accepted.
// Config writes are always ready and must only happen while the block is idle.
// Reading a store word that was never loaded returns an undefined value.
module tensor_gather_elements_top
  import tge_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // config write channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  // input transactions
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     cmd_i,
  input  logic [ADDR_W-1:0]        load_addr_i,
  input  logic [WORD_W-1:0]        load_value_i,
  input  logic signed [GIDX_W-1:0] gather_index_i,
  input  logic [POS_W-1:0]         pos_z_i,
  input  logic [POS_W-1:0]         pos_y_i,
  input  logic [POS_W-1:0]         pos_x_i,
  // result transactions
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [WORD_W-1:0]        value_o,
  output logic [ADDR_W-1:0]        source_addr_o,
  output logic                     error_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;  // waiting on the address pipeline
  localparam logic [1:0] ST_DONE = 2'd2;  // read data (or error) ready

  // ---------------- config registers ----------------
  tge_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rank         <= 2'd1;
      cfg_q.gather_axis  <= 3'sd0;
      cfg_q.width        <= DIM_W'(1);
      cfg_q.height       <= DIM_W'(1);
      cfg_q.channels     <= DIM_W'(1);
      cfg_q.channel_step <= STEP_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_RANK:     cfg_q.rank         <= cfg_data_i[1:0];
        REG_AXIS:     cfg_q.gather_axis  <= signed'(cfg_data_i[2:0]);
        REG_WIDTH:    cfg_q.width        <= cfg_data_i[DIM_W-1:0];
        REG_HEIGHT:   cfg_q.height       <= cfg_data_i[DIM_W-1:0];
        REG_CHANNELS: cfg_q.channels     <= cfg_data_i[DIM_W-1:0];
        REG_STEP:     cfg_q.channel_step <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- control ----------------
  logic [1:0] state_q, state_d;
  logic       in_acc, is_gather, start, cfg_err;
  logic       addr_done;
  logic [ADDR_W-1:0] calc_addr;
  logic       err_q;
  logic [ADDR_W-1:0] src_q;
  logic       rd_en, out_load;
  logic       out_valid_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_gather  = (cmd_i == CMD_GATHER);
  assign start      = in_acc && is_gather && !cfg_err;
  assign rd_en      = (state_q == ST_CALC) && addr_done;
  // result moves out when the output register is free or being drained
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && is_gather) begin
          state_d = cfg_err ? ST_DONE : ST_CALC;
        end
      end
      ST_CALC: begin
        if (addr_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_gather) begin
      err_q <= cfg_err;
    end
    if (rd_en) begin
      src_q <= calc_addr;
    end
  end

  // ---------------- address unit and store ----------------
  tge_addr u_addr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .start_i (start),
    .index_i (gather_index_i),
    .pos_z_i (pos_z_i),
    .pos_y_i (pos_y_i),
    .pos_x_i (pos_x_i),
    .err_o   (cfg_err),
    .done_o  (addr_done),
    .addr_o  (calc_addr)
  );

  logic [WORD_W-1:0] rdata;

  // loads write on acceptance; no read can be in flight then
  tge_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && !is_gather),
    .waddr_i (load_addr_i),
    .wdata_i (load_value_i),
    .re_i    (rd_en),
    .raddr_i (calc_addr),
    .rdata_o (rdata)
  );

  // ---------------- output register ----------------
  logic [WORD_W-1:0] value_q;
  logic [ADDR_W-1:0] oaddr_q;
  logic              oerr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      value_q <= err_q ? '0 : rdata;
      oaddr_q <= err_q ? '0 : src_q;
      oerr_q  <= err_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign value_o       = value_q;
  assign source_addr_o = oaddr_q;
  assign error_o       = oerr_q;

endmodule
